// ===== rtl/ppt_pkg.sv =====
// ============================================================================
// ppt_pkg - shared types and constants of the proximity presence tracker
// Entry and event records, register indexes, reset values and the
// sequencer states used across the tracker modules.
// ============================================================================
`default_nettype none

package ppt_pkg;

    // Table size default and result limit per input word
    localparam int DEF_ENTRIES = 16;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Field widths
    localparam int NODE_W     = 16;
    localparam int TIME_W     = 32;
    localparam int RSSI_W     = 8;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = NODE_W + RSSI_W + TIME_W;
    localparam int M_TDATA_W  = NODE_W + TIME_W + TIME_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RSSI_THR = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ABSENT   = 4'd3;

    // Register reset values
    localparam logic signed [RSSI_W-1:0] RST_RSSI_THR = -8'sd67;
    localparam logic [TIME_W-1:0]        RST_LOST     = 32'd640;
    localparam logic [TIME_W-1:0]        RST_DWELL    = 32'd3968;
    localparam logic [TIME_W-1:0]        RST_ABSENT   = 32'd3968;

    typedef enum logic [0:0] {
        CMD_SIGHT = 1'b0,
        CMD_SWEEP = 1'b1
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        EV_DETECT = 2'd0,
        EV_DWELL  = 2'd1,
        EV_LEAVE  = 2'd2,
        EV_GONE   = 2'd3
    } ev_kind_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [TIME_W-1:0] first_time;
        logic [TIME_W-1:0] dwell_start;
        logic [TIME_W-1:0] last_seen;
        logic              phase;
        logic              in_range;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        ev_kind_t          kind;
        logic [NODE_W-1:0] node;
        logic [TIME_W-1:0] spent;
    } event_t;

    typedef struct packed {
        logic signed [RSSI_W-1:0] rssi_thr;
        logic [TIME_W-1:0]        lost;
        logic [TIME_W-1:0]        dwell;
        logic [TIME_W-1:0]        absent;
    } cfg_t;

    // Requests from the sequencer to the output stage
    typedef struct packed {
        logic start;
        logic push;
        logic flush;
    } oreq_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SIGHT_UPD,
        ST_SW_READ,
        ST_SW_EVAL,
        ST_EMIT,
        ST_FLUSH
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/ppt_ram.sv =====
// ============================================================================
// ppt_ram - generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ============================================================================
`default_nettype none

module ppt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/ppt_eval.sv =====
// ============================================================================
// ppt_eval - entry update rules
// Given one entry and the operation, works out the rewritten entry, whether
// it stays allocated, and up to two events it raises.
// ============================================================================
`default_nettype none

module ppt_eval (
    input  wire logic                     sweep,
    input  wire ppt_pkg::entry_t          ent,
    input  wire ppt_pkg::cfg_t            cfg,
    input  wire logic [ppt_pkg::TIME_W-1:0] now,
    output      ppt_pkg::entry_t          ent_next,
    output      logic                     keep,
    output      logic                     ev0_v,
    output      ppt_pkg::event_t          ev0,
    output      logic                     ev1_v,
    output      ppt_pkg::event_t          ev1
);

    logic [ppt_pkg::TIME_W-1:0] latency;
    logic [ppt_pkg::TIME_W-1:0] age;
    logic [ppt_pkg::TIME_W-1:0] spent;

    // Elapsed times, modulo 2^32
    assign latency = now - ent.last_seen;
    assign age     = now - ent.first_time;
    assign spent   = now - ent.dwell_start;

    always_comb begin
        ent_next = ent;
        keep     = 1'b1;
        ev0_v    = 1'b0;
        ev1_v    = 1'b0;
        ev0      = '{kind: ppt_pkg::EV_DETECT, node: ent.node, spent: '0};
        ev1      = '{kind: ppt_pkg::EV_DWELL, node: ent.node, spent: '0};
        if (!sweep) begin
            // Sighting: refresh, report entry into range, then dwell
            ent_next.last_seen = now;
            if (!ent.in_range) begin
                ev0_v             = 1'b1;
                ent_next.in_range = 1'b1;
            end
            if (ent.phase) begin
                ent_next.first_time = now;
            end else if (age >= cfg.dwell) begin
                ev1_v                = 1'b1;
                ent_next.phase       = 1'b1;
                ent_next.first_time  = now;
                ent_next.dwell_start = now;
            end
        end else begin
            // Sweep: free lost phase-zero entries, report leave and gone
            if (!ent.phase) begin
                if (latency >= cfg.lost) begin
                    keep = 1'b0;
                end
            end else begin
                if (latency >= cfg.lost && ent.in_range) begin
                    ev0_v             = 1'b1;
                    ev0.kind          = ppt_pkg::EV_LEAVE;
                    ent_next.in_range = 1'b0;
                end
                if (age >= cfg.absent) begin
                    ev1_v     = 1'b1;
                    ev1.kind  = ppt_pkg::EV_GONE;
                    ev1.spent = spent;
                    keep      = 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ppt_out.sv =====
// ============================================================================
// ppt_out - event output stage
// Holds the newest event back one step so the final event of an input word
// can be marked, caps the count per word, and drives the result channel
// from an output register.
// ============================================================================
`default_nettype none

module ppt_out (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire ppt_pkg::oreq_t              req,
    input  wire ppt_pkg::event_t             ev,
    input  wire logic [ppt_pkg::TIME_W-1:0]  now,
    output      logic                        done,
    output      logic                        m_tvalid,
    input  wire logic                        m_tready,
    // m_tdata: reported_node [15:0], event_time [47:16], time_spent [79:48]
    output      logic [ppt_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: event_kind [1:0]
    output      logic [ppt_pkg::KIND_W-1:0]  m_tuser,
    output      logic                        m_tlast
);

    logic                         m_valid_reg;
    ppt_pkg::event_t              out_ev_reg;
    logic [ppt_pkg::TIME_W-1:0]   out_time_reg;
    logic                         out_last_reg;
    logic                         pend_v_reg;
    ppt_pkg::event_t              pend_reg;
    logic [ppt_pkg::CNT_W-1:0]    cnt_reg;

    logic out_free;
    logic load_out;
    logic out_last;
    logic pend_load;
    logic pend_clear;
    logic cnt_inc;

    assign out_free = !m_valid_reg || m_tready;

    // Decide push and flush moves
    always_comb begin
        done       = 1'b0;
        load_out   = 1'b0;
        out_last   = 1'b0;
        pend_load  = 1'b0;
        pend_clear = 1'b0;
        cnt_inc    = 1'b0;
        if (req.push) begin
            if (cnt_reg >= ppt_pkg::CNT_W'(ppt_pkg::MAX_RESULTS)) begin
                done = 1'b1;
            end else if (!pend_v_reg) begin
                pend_load = 1'b1;
                cnt_inc   = 1'b1;
                done      = 1'b1;
            end else if (out_free) begin
                load_out  = 1'b1;
                pend_load = 1'b1;
                cnt_inc   = 1'b1;
                done      = 1'b1;
            end
        end else if (req.flush) begin
            if (!pend_v_reg) begin
                done = 1'b1;
            end else if (out_free) begin
                load_out   = 1'b1;
                out_last   = 1'b1;
                pend_clear = 1'b1;
                done       = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pend_v_reg  <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (pend_load) begin
                pend_v_reg <= 1'b1;
            end else if (pend_clear) begin
                pend_v_reg <= 1'b0;
            end
            if (req.start) begin
                cnt_reg <= '0;
            end else if (cnt_inc) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_ev_reg   <= pend_reg;
            out_time_reg <= now;
            out_last_reg <= out_last;
        end
        if (pend_load) begin
            pend_reg <= ev;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_ev_reg.spent, out_time_reg, out_ev_reg.node};
    assign m_tuser  = out_ev_reg.kind;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/proximity_presence_tracker.sv =====
// ============================================================================
// proximity_presence_tracker - neighbor presence tracking from sightings
// Keeps a table of neighbor entries in one RAM and reports detect, dwell,
// leave and gone events on the result stream.
// ============================================================================
// One input word is handled at a time; the entry RAM, with its single read
// port, sets the pace. A sighting scans all ENTRIES entries to find the node
// or the lowest free entry, then rewrites one entry. A sweep reads each entry
// in turn and updates and writes back each occupied one. A stalled result
// channel adds its stall. Entry allocation is tracked by one valid flip-flop
// per entry, so the table is empty right after reset with no clearing pass.
// The configuration port is always ready; write registers only while no word
// is in progress. Each result word carries tlast on the final event caused by
// its input word; at most 32 events are reported per input word.
`default_nettype none

module proximity_presence_tracker #(
    parameter int ENTRIES = ppt_pkg::DEF_ENTRIES
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input stream
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // s_tdata: node_id [15:0], rssi [23:16], timestamp [55:24]
    input  wire logic [ppt_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: command [0]
    input  wire logic [0:0]                      s_tuser,
    // Result stream
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata: reported_node [15:0], event_time [47:16], time_spent [79:48]
    output      logic [ppt_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: event_kind [1:0]
    output      logic [ppt_pkg::KIND_W-1:0]      m_tuser,
    output      logic                            m_tlast,
    // Register writes
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [ppt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ppt_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int RC_W  = IDX_W + 1;

    // Registers
    ppt_pkg::state_t              state_reg,   state_next;
    ppt_pkg::cmd_t                cmd_reg,     cmd_next;
    logic [ppt_pkg::NODE_W-1:0]   node_reg,    node_next;
    logic [ppt_pkg::TIME_W-1:0]   now_reg,     now_next;
    logic [RC_W-1:0]              rd_cnt_reg,  rd_cnt_next;
    logic                         cmp_v_reg,   cmp_v_next;
    logic [IDX_W-1:0]             cmp_idx_reg, cmp_idx_next;
    logic                         match_reg,   match_next;
    logic                         free_v_reg,  free_v_next;
    logic [IDX_W-1:0]             slot_reg,    slot_next;
    ppt_pkg::entry_t              hit_ent_reg, hit_ent_next;
    logic [ENTRIES-1:0]           valid_reg,   valid_next;
    logic                         ev0_v_reg,   ev0_v_next;
    ppt_pkg::event_t              ev0_reg,     ev0_next;
    logic                         ev1_v_reg,   ev1_v_next;
    ppt_pkg::event_t              ev1_reg,     ev1_next;
    ppt_pkg::cfg_t                cfg_reg,     cfg_next;

    // RAM port signals
    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [ppt_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]             ram_raddr;
    logic [ppt_pkg::ENTRY_W-1:0]  ram_rdata;

    // Evaluation and output stage signals
    logic [IDX_W-1:0]             rd_idx;
    ppt_pkg::entry_t              scan_ent;
    ppt_pkg::entry_t              sw_ent;
    ppt_pkg::entry_t              sight_ent;
    ppt_pkg::entry_t              eval_ent;
    ppt_pkg::entry_t              eval_next;
    logic                         eval_keep;
    logic                         eval_ev0_v;
    ppt_pkg::event_t              eval_ev0;
    logic                         eval_ev1_v;
    ppt_pkg::event_t              eval_ev1;
    ppt_pkg::oreq_t               oreq;
    ppt_pkg::event_t              oev;
    logic                         odone;
    logic                         sw_last;
    logic                         sight_ok;

    // Entry RAM
    ppt_ram #(
        .WIDTH (ppt_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Free entries read as all zero
    assign rd_idx   = rd_cnt_reg[IDX_W-1:0];
    assign scan_ent = valid_reg[cmp_idx_reg] ? ppt_pkg::entry_t'(ram_rdata) : '0;
    assign sw_ent   = valid_reg[rd_idx] ? ppt_pkg::entry_t'(ram_rdata) : '0;

    // Sighting target: the matched entry, or a fresh one in the free slot
    always_comb begin
        sight_ent = '0;
        if (match_reg) begin
            sight_ent = hit_ent_reg;
        end else begin
            sight_ent.node       = node_reg;
            sight_ent.first_time = now_reg;
        end
    end

    assign eval_ent = (state_reg == ppt_pkg::ST_SIGHT_UPD) ? sight_ent : sw_ent;

    ppt_eval u_eval (
        .sweep    (cmd_reg == ppt_pkg::CMD_SWEEP),
        .ent      (eval_ent),
        .cfg      (cfg_reg),
        .now      (now_reg),
        .ent_next (eval_next),
        .keep     (eval_keep),
        .ev0_v    (eval_ev0_v),
        .ev0      (eval_ev0),
        .ev1_v    (eval_ev1_v),
        .ev1      (eval_ev1)
    );

    ppt_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (oreq),
        .ev       (oev),
        .now      (now_reg),
        .done     (odone),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    assign s_tready = (state_reg == ppt_pkg::ST_IDLE);
    assign sw_last  = (rd_cnt_reg == RC_W'(ENTRIES - 1));
    assign sight_ok = (s_tdata[15:0] != '0) &&
                      ($signed(s_tdata[23:16]) >= $signed(cfg_reg.rssi_thr));
    assign oev      = ev0_v_reg ? ev0_reg : ev1_reg;

    // Sequencer: next state and datapath controls
    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        node_next    = node_reg;
        now_next     = now_reg;
        rd_cnt_next  = rd_cnt_reg;
        cmp_v_next   = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        match_next   = match_reg;
        free_v_next  = free_v_reg;
        slot_next    = slot_reg;
        hit_ent_next = hit_ent_reg;
        valid_next   = valid_reg;
        ev0_v_next   = ev0_v_reg;
        ev0_next     = ev0_reg;
        ev1_v_next   = ev1_v_reg;
        ev1_next     = ev1_reg;
        ram_we       = 1'b0;
        ram_waddr    = rd_idx;
        ram_wdata    = eval_next;
        ram_raddr    = rd_idx;
        oreq         = '0;

        case (state_reg)
            ppt_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next    = ppt_pkg::cmd_t'(s_tuser[0]);
                    node_next   = s_tdata[15:0];
                    now_next    = s_tdata[55:24];
                    rd_cnt_next = '0;
                    match_next  = 1'b0;
                    free_v_next = 1'b0;
                    oreq.start  = 1'b1;
                    if (s_tuser[0] == ppt_pkg::CMD_SWEEP) begin
                        state_next = ppt_pkg::ST_SW_READ;
                    end else if (sight_ok) begin
                        state_next = ppt_pkg::ST_SCAN;
                    end
                end
            end

            ppt_pkg::ST_SCAN: begin
                // Issue one read a cycle, compare the word read last cycle
                if (rd_cnt_reg < RC_W'(ENTRIES)) begin
                    rd_cnt_next  = rd_cnt_reg + 1'b1;
                    cmp_v_next   = 1'b1;
                    cmp_idx_next = rd_idx;
                end
                if (cmp_v_reg) begin
                    if (valid_reg[cmp_idx_reg] && scan_ent.node == node_reg) begin
                        match_next   = 1'b1;
                        slot_next    = cmp_idx_reg;
                        hit_ent_next = scan_ent;
                    end else if (!valid_reg[cmp_idx_reg] && !free_v_reg && !match_reg) begin
                        free_v_next = 1'b1;
                        slot_next   = cmp_idx_reg;
                    end
                    if (cmp_idx_reg == IDX_W'(ENTRIES - 1)) begin
                        state_next = ppt_pkg::ST_SIGHT_UPD;
                    end
                end
            end

            ppt_pkg::ST_SIGHT_UPD: begin
                if (match_reg || free_v_reg) begin
                    ram_we                = 1'b1;
                    ram_waddr             = slot_reg;
                    valid_next[slot_reg]  = 1'b1;
                    ev0_v_next            = eval_ev0_v;
                    ev0_next              = eval_ev0;
                    ev1_v_next            = eval_ev1_v;
                    ev1_next              = eval_ev1;
                    state_next            = ppt_pkg::ST_EMIT;
                end else begin
                    // Full table: drop the sighting
                    state_next = ppt_pkg::ST_FLUSH;
                end
            end

            ppt_pkg::ST_SW_READ: begin
                state_next = ppt_pkg::ST_SW_EVAL;
            end

            ppt_pkg::ST_SW_EVAL: begin
                if (valid_reg[rd_idx]) begin
                    if (eval_keep) begin
                        ram_we = 1'b1;
                    end else begin
                        valid_next[rd_idx] = 1'b0;
                    end
                    ev0_v_next = eval_ev0_v;
                    ev0_next   = eval_ev0;
                    ev1_v_next = eval_ev1_v;
                    ev1_next   = eval_ev1;
                    state_next = ppt_pkg::ST_EMIT;
                end else begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                    state_next  = sw_last ? ppt_pkg::ST_FLUSH : ppt_pkg::ST_SW_READ;
                end
            end

            ppt_pkg::ST_EMIT: begin
                // Hand events to the output stage in order
                if (ev0_v_reg || ev1_v_reg) begin
                    oreq.push = 1'b1;
                    if (odone) begin
                        if (ev0_v_reg) begin
                            ev0_v_next = 1'b0;
                        end else begin
                            ev1_v_next = 1'b0;
                        end
                    end
                end else if (cmd_reg == ppt_pkg::CMD_SWEEP) begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                    state_next  = sw_last ? ppt_pkg::ST_FLUSH : ppt_pkg::ST_SW_READ;
                end else begin
                    state_next = ppt_pkg::ST_FLUSH;
                end
            end

            ppt_pkg::ST_FLUSH: begin
                // Release the held event marked as last
                oreq.flush = 1'b1;
                if (odone) begin
                    state_next = ppt_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = ppt_pkg::ST_IDLE;
            end
        endcase
    end

    // Register writes
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                ppt_pkg::CFG_RSSI_THR: cfg_next.rssi_thr = cfg_data[7:0];
                ppt_pkg::CFG_LOST:     cfg_next.lost     = cfg_data;
                ppt_pkg::CFG_DWELL:    cfg_next.dwell    = cfg_data;
                ppt_pkg::CFG_ABSENT:   cfg_next.absent   = cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ppt_pkg::ST_IDLE;
            cmp_v_reg <= 1'b0;
            valid_reg <= '0;
            ev0_v_reg <= 1'b0;
            ev1_v_reg <= 1'b0;
            match_reg <= 1'b0;
            free_v_reg <= 1'b0;
            cfg_reg   <= '{rssi_thr: ppt_pkg::RST_RSSI_THR,
                           lost:     ppt_pkg::RST_LOST,
                           dwell:    ppt_pkg::RST_DWELL,
                           absent:   ppt_pkg::RST_ABSENT};
        end else begin
            state_reg  <= state_next;
            cmp_v_reg  <= cmp_v_next;
            valid_reg  <= valid_next;
            ev0_v_reg  <= ev0_v_next;
            ev1_v_reg  <= ev1_v_next;
            match_reg  <= match_next;
            free_v_reg <= free_v_next;
            cfg_reg    <= cfg_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        node_reg    <= node_next;
        now_reg     <= now_next;
        rd_cnt_reg  <= rd_cnt_next;
        cmp_idx_reg <= cmp_idx_next;
        slot_reg    <= slot_next;
        hit_ent_reg <= hit_ent_next;
        ev0_reg     <= ev0_next;
        ev1_reg     <= ev1_next;
    end

endmodule

`default_nettype wire

// ===== dv/proximity_presence_tracker_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// proximity_presence_tracker_tb - self-checking bench of the presence tracker
// Drives sightings and aging sweeps on the input stream, and writes the
// registers between phases while the block is idle. Every event word is
// compared field by field with a behavioral copy of the neighbor table or
// with the event of its directed row. A directed table opens the run; random
// phases over small node pools follow, each with its own register setting.
// ============================================================================

module proximity_presence_tracker_tb;

    import ppt_pkg::*;

    localparam int ENTRIES      = DEF_ENTRIES;
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_CYCLES = 12 * ENTRIES + 40;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int IDLE_PCT     = 11;
    localparam int PHASE_WORDS  = 56;
    localparam int NUM_PHASES   = 6;
    localparam int POOL_MAX     = 20;

    // Indexes that map to no register
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 4'd9;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 4'hF;

    typedef enum logic [0:0] {
        ROW_WORD,
        ROW_REG
    } row_kind_t;

    // How a directed row is checked
    typedef enum logic [1:0] {
        BY_MODEL,
        NO_EVENT,
        ONE_EVENT
    } check_t;

    typedef struct {
        row_kind_t                kind;
        cmd_t                     cmd;
        logic [NODE_W-1:0]        node;
        logic signed [RSSI_W-1:0] rssi;
        logic [TIME_W-1:0]        stamp;
        logic [CFG_IDX_W-1:0]     reg_idx;
        logic [CFG_DATA_W-1:0]    reg_val;
        check_t                   check;
        ev_kind_t                 ev;
    } row_t;

    typedef struct {
        logic signed [RSSI_W-1:0] thr;
        logic [TIME_W-1:0]        lost;
        logic [TIME_W-1:0]        dwell;
        logic [TIME_W-1:0]        absent;
        int                       pool_size;
        int                       max_step;
        bit                       calm;
    } phase_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [TIME_W-1:0] first_t;
        logic [TIME_W-1:0] dwell_t;
        logic [TIME_W-1:0] seen_t;
        logic              phase;
        logic              near;
    } slot_t;

    typedef struct packed {
        ev_kind_t          kind;
        logic [NODE_W-1:0] node;
        logic [TIME_W-1:0] at;
        logic [TIME_W-1:0] spent;
        logic              last;
    } event_rec_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [S_TDATA_W-1:0]       s_tdata;   // node_id, rssi, timestamp
    logic [0:0]                 s_tuser;   // command
    logic                       m_tvalid;
    logic                       m_tready;
    logic [M_TDATA_W-1:0]       m_tdata;   // reported_node, event_time, time_spent
    logic [KIND_W-1:0]          m_tuser;   // event_kind
    logic                       m_tlast;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    // Shadow registers and neighbor table
    logic signed [RSSI_W-1:0]   thr_dbm;
    logic [TIME_W-1:0]          lost_lim;
    logic [TIME_W-1:0]          dwell_lim;
    logic [TIME_W-1:0]          absent_lim;
    slot_t                      slots [ENTRIES];

    event_rec_t                 step_events [$];
    event_rec_t                 awaited_events [$];

    int                         mismatches = 0;
    int                         cycles = 0;
    bit                         calm = 1'b0;

    proximity_presence_tracker #(
        .ENTRIES (ENTRIES)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    always begin
        aclk = 1'b0;
        #CLK_HALF;
        aclk = 1'b1;
        #CLK_HALF;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result-side backpressure
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Presence tracking, mirrored
    // ------------------------------------------------------------------------

    function automatic void log_event(ev_kind_t kind, logic [NODE_W-1:0] node,
                                      logic [TIME_W-1:0] at, logic [TIME_W-1:0] spent);
        event_rec_t ev;
        if (step_events.size() >= MAX_RESULTS)
            return;
        ev = '{kind: kind, node: node, at: at, spent: spent, last: 1'b0};
        step_events.push_back(ev);
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_RSSI_THR: thr_dbm    = val[RSSI_W-1:0];
            CFG_LOST:     lost_lim   = val;
            CFG_DWELL:    dwell_lim  = val;
            CFG_ABSENT:   absent_lim = val;
            default: ;
        endcase
    endfunction

    // Work out the events one input word causes, into step_events
    function automatic void track_word(cmd_t cmd, logic [NODE_W-1:0] node,
                                       logic signed [RSSI_W-1:0] rssi,
                                       logic [TIME_W-1:0] now);
        int          hit;
        logic [TIME_W-1:0] age;
        event_rec_t  tail;
        step_events.delete();
        hit = -1;
        if (cmd == CMD_SIGHT) begin
            if (node != '0 && rssi >= thr_dbm) begin
                for (int k = 0; k < ENTRIES; k++)
                    if (slots[k].node == node)
                        hit = k;
                // Unknown node: take the lowest free entry, or drop when full
                if (hit < 0) begin
                    for (int k = 0; k < ENTRIES; k++)
                        if (hit < 0 && slots[k].node == '0)
                            hit = k;
                    if (hit >= 0) begin
                        slots[hit]         = '0;
                        slots[hit].node    = node;
                        slots[hit].first_t = now;
                    end
                end
                if (hit >= 0) begin
                    slots[hit].seen_t = now;
                    if (!slots[hit].near) begin
                        log_event(EV_DETECT, node, now, '0);
                        slots[hit].near = 1'b1;
                    end
                    if (slots[hit].phase) begin
                        slots[hit].first_t = now;
                    end else if (TIME_W'(now - slots[hit].first_t) >= dwell_lim) begin
                        log_event(EV_DWELL, node, now, '0);
                        slots[hit].phase   = 1'b1;
                        slots[hit].first_t = now;
                        slots[hit].dwell_t = now;
                    end
                end
            end
        end else begin
            // Age every occupied entry
            for (int k = 0; k < ENTRIES; k++) begin
                if (slots[k].node != '0) begin
                    age = now - slots[k].seen_t;
                    if (!slots[k].phase) begin
                        if (age >= lost_lim)
                            slots[k] = '0;
                    end else begin
                        if (age >= lost_lim && slots[k].near) begin
                            log_event(EV_LEAVE, slots[k].node, now, '0);
                            slots[k].near = 1'b0;
                        end
                        if (TIME_W'(now - slots[k].first_t) >= absent_lim) begin
                            log_event(EV_GONE, slots[k].node, now,
                                      TIME_W'(now - slots[k].dwell_t));
                            slots[k] = '0;
                        end
                    end
                end
            end
        end
        // Mark the final event of this word
        if (step_events.size() > 0) begin
            tail      = step_events.pop_back();
            tail.last = 1'b1;
            step_events.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Event checking
    // ------------------------------------------------------------------------

    always @(posedge aclk) begin : check_events
        event_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_events.size() == 0) begin
                $error("unexpected event word: kind %0d node %h time %h",
                       m_tuser, m_tdata[15:0], m_tdata[47:16]);
                mismatches++;
            end else begin
                want = awaited_events.pop_front();
                if (m_tuser !== want.kind) begin
                    $error("event_kind: expected %0d, got %0d", want.kind, m_tuser);
                    mismatches++;
                end
                if (m_tdata[15:0] !== want.node) begin
                    $error("reported_node: expected %h, got %h", want.node, m_tdata[15:0]);
                    mismatches++;
                end
                if (m_tdata[47:16] !== want.at) begin
                    $error("event_time: expected %h, got %h", want.at, m_tdata[47:16]);
                    mismatches++;
                end
                if (m_tdata[79:48] !== want.spent) begin
                    $error("time_spent: expected %h, got %h", want.spent, m_tdata[79:48]);
                    mismatches++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_event: expected %0d, got %0d", want.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Send one word; on acceptance, predict its events
    task automatic send_word(cmd_t cmd, logic [NODE_W-1:0] node,
                             logic signed [RSSI_W-1:0] rssi, logic [TIME_W-1:0] stamp,
                             bit by_model);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {stamp, rssi, node};
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        track_word(cmd, node, rssi, stamp);
        if (by_model)
            foreach (step_events[i])
                awaited_events.push_back(step_events[i]);
    endtask

    // Write one register; valid stays high for a following write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        apply_reg(idx, val);
    endtask

    // Drop valids, drain all events, then let the block go quiet
    task automatic settle();
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (awaited_events.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic row_t word_row(cmd_t cmd, logic [NODE_W-1:0] node,
                                      logic signed [RSSI_W-1:0] rssi,
                                      logic [TIME_W-1:0] stamp, check_t check,
                                      ev_kind_t ev);
        row_t r;
        r = '{kind: ROW_WORD, cmd: cmd, node: node, rssi: rssi, stamp: stamp,
              reg_idx: '0, reg_val: '0, check: check, ev: ev};
        return r;
    endfunction

    function automatic row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        row_t r;
        r = '{kind: ROW_REG, cmd: CMD_SIGHT, node: '0, rssi: '0, stamp: '0,
              reg_idx: idx, reg_val: val, check: NO_EVENT, ev: EV_DETECT};
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    initial begin : stimulus
        row_t                     plan [$];
        phase_t                   phases [NUM_PHASES];
        logic [NODE_W-1:0]        pool [POOL_MAX];
        logic [TIME_W-1:0]        now;
        logic signed [RSSI_W-1:0] rssi_v;
        event_rec_t               typed;
        row_kind_t                prev_kind;
        int                       roll;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_SIGHT;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_RSSI_THR;
        cfg_data  <= '0;

        thr_dbm    = RST_RSSI_THR;
        lost_lim   = RST_LOST;
        dwell_lim  = RST_DWELL;
        absent_lim = RST_ABSENT;
        foreach (slots[k])
            slots[k] = '0;

        // Reset-value registers: threshold edge, ignored sightings, full life cycle
        plan.push_back(word_row(CMD_SIGHT, 16'h0001, -8'sd67, 32'd100, ONE_EVENT, EV_DETECT));
        plan.push_back(word_row(CMD_SIGHT, 16'h0000, 8'sd127, 32'd110, NO_EVENT, EV_DETECT));
        plan.push_back(word_row(CMD_SIGHT, 16'h0002, -8'sd68, 32'd120, NO_EVENT, EV_DETECT));
        plan.push_back(word_row(CMD_SIGHT, 16'hFFFF, 8'sd127, 32'd130, ONE_EVENT, EV_DETECT));
        plan.push_back(word_row(CMD_SIGHT, 16'h0001, 8'sd0, 32'd4068, BY_MODEL, EV_DWELL));
        plan.push_back(word_row(CMD_SWEEP, 16'h0000, 8'sd0, 32'd4800, BY_MODEL, EV_LEAVE));
        plan.push_back(word_row(CMD_SWEEP, 16'h0000, 8'sd0, 32'd8036, BY_MODEL, EV_GONE));
        plan.push_back(word_row(CMD_SWEEP, 16'hFFFF, -8'sd128, 32'hFFFF_FFFF,
                                NO_EVENT, EV_DETECT));
        // Highest threshold, zero lost and dwell, largest absent, spare indexes that must change nothing
        plan.push_back(reg_row(CFG_RSSI_THR, 32'h0000_007F));
        plan.push_back(reg_row(CFG_LOST, 32'h0000_0000));
        plan.push_back(reg_row(CFG_DWELL, 32'h0000_0000));
        plan.push_back(reg_row(CFG_ABSENT, 32'hFFFF_FFFF));
        plan.push_back(reg_row(CFG_IDX_SPARE, 32'h0000_0080));
        plan.push_back(reg_row(CFG_IDX_TOP, 32'h0000_0000));
        plan.push_back(word_row(CMD_SIGHT, 16'h1234, 8'sd126, 32'hFFFF_FFF0,
                                NO_EVENT, EV_DETECT));
        plan.push_back(word_row(CMD_SIGHT, 16'h1234, 8'sd127, 32'hFFFF_FFF0,
                                BY_MODEL, EV_DWELL));
        plan.push_back(word_row(CMD_SWEEP, 16'h0000, 8'sd0, 32'h0000_0005, BY_MODEL, EV_LEAVE));
        plan.push_back(word_row(CMD_SIGHT, 16'h1234, 8'sd127, 32'h0000_0010,
                                ONE_EVENT, EV_DETECT));
        // Lowest threshold, largest lost and dwell, zero absent: gone across the wrap
        plan.push_back(reg_row(CFG_RSSI_THR, 32'hFFFF_FF80));
        plan.push_back(reg_row(CFG_ABSENT, 32'h0000_0000));
        plan.push_back(reg_row(CFG_LOST, 32'hFFFF_FFFF));
        plan.push_back(reg_row(CFG_DWELL, 32'hFFFF_FFFF));
        plan.push_back(word_row(CMD_SWEEP, 16'h0000, 8'sd0, 32'h0000_0020, BY_MODEL, EV_GONE));
        plan.push_back(word_row(CMD_SIGHT, 16'h00FF, -8'sd128, 32'h0000_0030,
                                ONE_EVENT, EV_DETECT));
        plan.push_back(word_row(CMD_SIGHT, 16'h00FF, -8'sd128, 32'h0000_0031,
                                NO_EVENT, EV_DETECT));

        phases[0] = '{-8'sd80, 32'd30, 32'd60, 32'd120, 6, 12, 1'b0};
        phases[1] = '{-8'sd128, 32'd40, 32'd0, 32'd0, 10, 15, 1'b0};
        phases[2] = '{8'sd0, 32'd25, 32'd50, 32'd90, 20, 6, 1'b1};
        phases[3] = '{8'sd127, 32'd1, 32'd1, 32'd1, 4, 2, 1'b0};
        phases[4] = '{-8'sd67, 32'hFFFF_FFFF, 32'd20, 32'hFFFF_FFFF, 18, 8, 1'b0};
        phases[5] = '{RST_RSSI_THR, RST_LOST, RST_DWELL, RST_ABSENT, 8, 300, 1'b0};

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table
        prev_kind = ROW_WORD;
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                if (prev_kind == ROW_WORD)
                    settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                if (prev_kind == ROW_REG)
                    cfg_valid <= 1'b0;
                send_word(plan[i].cmd, plan[i].node, plan[i].rssi, plan[i].stamp,
                          plan[i].check == BY_MODEL);
                if (plan[i].check == ONE_EVENT) begin
                    typed = '{kind: plan[i].ev, node: plan[i].node, at: plan[i].stamp,
                              spent: '0, last: 1'b1};
                    awaited_events.push_back(typed);
                end
            end
            prev_kind = plan[i].kind;
        end

        // Random phases: sightings and sweeps over advancing time, mostly of a small node pool
        foreach (phases[p]) begin
            settle();
            calm = phases[p].calm;
            write_reg(CFG_RSSI_THR, {{(CFG_DATA_W-RSSI_W){1'b0}}, phases[p].thr});
            write_reg(CFG_LOST, phases[p].lost);
            write_reg(CFG_DWELL, phases[p].dwell);
            write_reg(CFG_ABSENT, phases[p].absent);
            cfg_valid <= 1'b0;
            foreach (pool[k])
                pool[k] = NODE_W'($urandom_range(1, 16'hFFFF));
            now = (p == 0) ? 32'hFFFF_FF80 : $urandom;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                roll = $urandom_range(0, 99);
                now  = now + $urandom_range(0, phases[p].max_step);
                if (roll < 12) begin
                    send_word(cmd_t'($urandom_range(0, 1)), NODE_W'($urandom),
                              RSSI_W'($urandom), $urandom, 1'b1);
                end else if (roll < 30) begin
                    send_word(CMD_SWEEP, pool[$urandom_range(0, phases[p].pool_size - 1)],
                              RSSI_W'($urandom), now, 1'b1);
                end else begin
                    if ($urandom_range(0, 9) == 0)
                        rssi_v = RSSI_W'($urandom);
                    else
                        rssi_v = RSSI_W'($urandom_range(int'(phases[p].thr) + 128, 255)
                                         - 128);
                    send_word(CMD_SIGHT, pool[$urandom_range(0, phases[p].pool_size - 1)],
                              rssi_v, now, 1'b1);
                end
            end
        end

        calm = 1'b0;
        settle();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
